// File: src/chained_hash_table_unit_defines.svh
// ----------------------------------------------------------------------------
// chained hash table assertion macros
// shared concurrent assertion forms for the port checker
// ----------------------------------------------------------------------------
`ifndef CHAINED_HASH_TABLE_UNIT_DEFINES_SVH
`define CHAINED_HASH_TABLE_UNIT_DEFINES_SVH

// property checked outside reset
`define CHT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked also while reset is high
`define CHT_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/cht_pkg.sv
// ----------------------------------------------------------------------------
// cht_pkg
// shared codes and controller/datapath interface types of the hash table
// ----------------------------------------------------------------------------
package cht_pkg;

  // operation selector
  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_LOOKUP = 2'd1,
    FUNC_DELETE = 2'd2,
    FUNC_SPARE  = 2'd3
  } func_t;

  // result status
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_MISS  = 2'd1,
    ST_FULL  = 2'd2,
    ST_SPARE = 2'd3
  } status_t;

  // register map
  localparam logic [2:0]  ADDR_BUCKET_COUNT  = 3'd0;
  localparam logic [10:0] BUCKET_COUNT_RESET = 11'd1024;

  // commands from controller to datapath
  typedef struct packed {
    logic    clear_step;
    logic    load_item;
    logic    head_rd;
    logic    walk_init;
    logic    node_rd;
    logic    walk_adv;
    logic    ins_node;
    logic    ins_link;
    logic    del_commit;
    logic    res_load;
    logic    res_use_val;
    status_t res_status;
    logic    out_load;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic clear_done;
    logic div_done;
    logic is_insert;
    logic is_delete;
    logic pool_empty;
    logic head_valid;
    logic cur_valid;
    logic key_match;
    logic out_free;
  } sts_t;

endpackage

// File: src/cht_divider.sv
// ----------------------------------------------------------------------------
// cht_divider
// restoring remainder unit, one key bit per cycle
// ----------------------------------------------------------------------------
module cht_divider #(
  parameter int KW = 32,
  parameter int DW = 11
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [KW-1:0] key,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] rem
);

  localparam int CNTW = (KW > 1) ? $clog2(KW) : 1;

  logic            busy;
  logic [CNTW-1:0] cnt;
  logic [KW-1:0]   shreg;
  logic [DW-1:0]   dvs;
  logic [DW:0]     trial;
  logic [DW:0]     diff;
  logic            last;

  assign last  = (cnt == CNTW'(KW - 1));
  assign trial = {rem, shreg[KW-1]};
  assign diff  = trial - {1'b0, dvs};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && last;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (last) busy <= 1'b0;
      end
    end
  end

  // shift and subtract
  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= key;
      dvs   <= divisor;
      rem   <= '0;
    end else if (busy) begin
      shreg <= {shreg[KW-2:0], 1'b0};
      if (trial >= {1'b0, dvs}) rem <= diff[DW-1:0];
      else rem <= trial[DW-1:0];
    end
  end

endmodule

// File: src/cht_datapath.sv
// ----------------------------------------------------------------------------
// cht_datapath
// bucket and node memories, free stack, counters, walk registers, output stage
// ----------------------------------------------------------------------------
module cht_datapath
  import cht_pkg::*;
#(
  parameter int MAX_BUCKETS = 1024,
  parameter int POOL_DEPTH  = 1024,
  parameter int KEY_BITS    = 32,
  parameter int VALUE_BITS  = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic [10:0] bucket_count,
  input  logic [71:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata
);

  localparam int BW    = (MAX_BUCKETS > 2) ? $clog2(MAX_BUCKETS) : 1;
  localparam int DW    = $clog2(MAX_BUCKETS + 1);
  localparam int NW    = (POOL_DEPTH > 2) ? $clog2(POOL_DEPTH) : 1;
  localparam int FW    = $clog2(POOL_DEPTH + 1);
  localparam int KW    = (KEY_BITS < 32) ? KEY_BITS : 32;
  localparam int VW    = (VALUE_BITS < 32) ? VALUE_BITS : 32;
  localparam int CW    = (DW > 11) ? DW : 11;
  localparam int CLR_N = (MAX_BUCKETS > POOL_DEPTH) ? MAX_BUCKETS : POOL_DEPTH;
  localparam int CLW   = $clog2(CLR_N);

  // pointer: valid bit on top of a node index
  logic [NW:0] heads [MAX_BUCKETS];
  logic [NW:0] tails [MAX_BUCKETS];
  logic [KW-1:0] node_keys [POOL_DEPTH];
  logic [VW-1:0] node_vals [POOL_DEPTH];
  logic [NW:0]   node_links [POOL_DEPTH];
  logic [NW-1:0] free_stack [POOL_DEPTH];

  logic [NW:0]   hd_q, td_q, lq;
  logic [KW-1:0] kq;
  logic [VW-1:0] vq;
  logic [NW-1:0] fs_q;

  logic [CLW-1:0] clr_cnt;
  logic [FW-1:0]  free_cnt, entry_cnt, used_cnt;
  logic [FW-1:0]  free_dec;

  func_t         func_r;
  logic [KW-1:0] key_r;
  logic [VW-1:0] val_r;
  logic [BW-1:0] bucket;
  logic [NW:0]   cur, prev;

  status_t       res_status;
  logic [VW-1:0] res_val;

  logic [CW-1:0] bc_ext;
  logic [DW-1:0] divisor;
  logic [DW-1:0] rem;
  logic          div_done;

  // effective bucket count: zero acts as one, saturate at the maximum
  assign bc_ext = CW'(bucket_count);
  always_comb begin
    if (bc_ext == '0) divisor = DW'(1);
    else if (bc_ext > CW'(MAX_BUCKETS)) divisor = DW'(MAX_BUCKETS);
    else divisor = bc_ext[DW-1:0];
  end

  cht_divider #(.KW(KW), .DW(DW)) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.load_item),
    .key     (s_tdata[KW+1:2]),
    .divisor (divisor),
    .done    (div_done),
    .rem     (rem)
  );

  // item registers
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      func_r <= func_t'(s_tdata[1:0]);
      key_r  <= s_tdata[KW+1:2];
      val_r  <= s_tdata[VW+33:34];
    end
    if (div_done) bucket <= rem[BW-1:0];
  end

  // clearing pass counter
  always_ff @(posedge clk) begin
    if (rst) clr_cnt <= '0;
    else if (cmd.clear_step && clr_cnt != CLW'(CLR_N - 1)) clr_cnt <= clr_cnt + 1'b1;
  end

  // bucket memories
  logic          clr_b, clr_f;
  logic [NW-1:0] new_node;
  assign clr_b    = ({1'b0, clr_cnt} < (CLW+1)'(MAX_BUCKETS));
  assign clr_f    = ({1'b0, clr_cnt} < (CLW+1)'(POOL_DEPTH));
  assign new_node = fs_q;

  always_ff @(posedge clk) begin
    if (cmd.clear_step && clr_b) begin
      heads[clr_cnt[BW-1:0]] <= '0;
      tails[clr_cnt[BW-1:0]] <= '0;
    end else if (cmd.ins_node) begin
      if (!hd_q[NW]) heads[bucket] <= {1'b1, new_node};
      tails[bucket] <= {1'b1, new_node};
    end else if (cmd.del_commit) begin
      if (!prev[NW]) heads[bucket] <= lq;
      if (!lq[NW]) tails[bucket] <= prev;
    end
    if (cmd.head_rd) begin
      hd_q <= heads[bucket];
      td_q <= tails[bucket];
    end
  end

  // node memories
  always_ff @(posedge clk) begin
    if (cmd.ins_node) begin
      node_keys[new_node]  <= key_r;
      node_vals[new_node]  <= val_r;
      node_links[new_node] <= '0;
    end else if (cmd.ins_link) begin
      node_links[td_q[NW-1:0]] <= {1'b1, new_node};
    end else if (cmd.del_commit && prev[NW]) begin
      node_links[prev[NW-1:0]] <= lq;
    end
    if (cmd.node_rd) begin
      kq <= node_keys[cur[NW-1:0]];
      vq <= node_vals[cur[NW-1:0]];
      lq <= node_links[cur[NW-1:0]];
    end
  end

  // free stack
  assign free_dec = free_cnt - 1'b1;
  always_ff @(posedge clk) begin
    if (cmd.clear_step && clr_f) begin
      free_stack[clr_cnt[NW-1:0]] <= NW'(POOL_DEPTH - 1) - clr_cnt[NW-1:0];
    end else if (cmd.del_commit) begin
      free_stack[free_cnt[NW-1:0]] <= cur[NW-1:0];
    end
    if (cmd.head_rd) fs_q <= free_stack[free_dec[NW-1:0]];
  end

  // counters
  always_ff @(posedge clk) begin
    if (rst) begin
      free_cnt  <= FW'(POOL_DEPTH);
      entry_cnt <= '0;
      used_cnt  <= '0;
    end else if (cmd.ins_node) begin
      free_cnt  <= free_dec;
      entry_cnt <= entry_cnt + 1'b1;
      if (!hd_q[NW]) used_cnt <= used_cnt + 1'b1;
    end else if (cmd.del_commit) begin
      free_cnt  <= free_cnt + 1'b1;
      entry_cnt <= entry_cnt - 1'b1;
      if (!prev[NW] && !lq[NW]) used_cnt <= used_cnt - 1'b1;
    end
  end

  // chain walk registers
  always_ff @(posedge clk) begin
    if (cmd.walk_init) begin
      cur  <= hd_q;
      prev <= '0;
    end else if (cmd.walk_adv) begin
      prev <= cur;
      cur  <= lq;
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_status <= cmd.res_status;
      res_val    <= cmd.res_use_val ? vq : '0;
    end
  end

  // output stage
  logic [FW+10:0] item_ext, used_ext;
  logic [VW+31:0] val_ext;
  assign item_ext = {11'b0, entry_cnt};
  assign used_ext = {11'b0, used_cnt};
  assign val_ext  = {32'b0, res_val};

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (cmd.out_load) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= {used_ext[10:0], item_ext[10:0], val_ext[31:0], res_status};
    end
  end

  // status to controller
  always_comb begin
    sts.clear_done = (clr_cnt == CLW'(CLR_N - 1));
    sts.div_done   = div_done;
    sts.is_insert  = (func_r == FUNC_INSERT);
    sts.is_delete  = (func_r == FUNC_DELETE);
    sts.pool_empty = (free_cnt == '0);
    sts.head_valid = hd_q[NW];
    sts.cur_valid  = cur[NW];
    sts.key_match  = (kq == key_r);
    sts.out_free   = !m_tvalid || m_tready;
  end

endmodule

// File: src/cht_ctrl.sv
// ----------------------------------------------------------------------------
// cht_ctrl
// operation sequencer: clearing pass, modulo, head read, insert or chain walk
// ----------------------------------------------------------------------------
module cht_ctrl
  import cht_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [10:0] {
    S_CLEAR     = 11'b00000000001,
    S_IDLE      = 11'b00000000010,
    S_DIV       = 11'b00000000100,
    S_HEAD_RD   = 11'b00000001000,
    S_HEAD_WAIT = 11'b00000010000,
    S_INS_NODE  = 11'b00000100000,
    S_INS_LINK  = 11'b00001000000,
    S_WALK      = 11'b00010000000,
    S_NODE_WAIT = 11'b00100000000,
    S_DEL       = 11'b01000000000,
    S_OUT       = 11'b10000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else state <= state_next;
  end

  assign s_tready = (state == S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.res_status = ST_OK;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load_item = 1'b1;
          state_next    = S_DIV;
        end
      end
      S_DIV: begin
        if (sts.div_done) state_next = S_HEAD_RD;
      end
      S_HEAD_RD: begin
        cmd.head_rd = 1'b1;
        state_next  = S_HEAD_WAIT;
      end
      S_HEAD_WAIT: begin
        if (sts.is_insert) begin
          if (sts.pool_empty) begin
            cmd.res_load   = 1'b1;
            cmd.res_status = ST_FULL;
            state_next     = S_OUT;
          end else begin
            state_next = S_INS_NODE;
          end
        end else begin
          cmd.walk_init = 1'b1;
          state_next    = S_WALK;
        end
      end
      S_INS_NODE: begin
        cmd.ins_node   = 1'b1;
        cmd.res_load   = 1'b1;
        cmd.res_status = ST_OK;
        state_next     = sts.head_valid ? S_INS_LINK : S_OUT;
      end
      S_INS_LINK: begin
        cmd.ins_link = 1'b1;
        state_next   = S_OUT;
      end
      S_WALK: begin
        if (sts.cur_valid) begin
          cmd.node_rd = 1'b1;
          state_next  = S_NODE_WAIT;
        end else begin
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_MISS;
          state_next     = S_OUT;
        end
      end
      S_NODE_WAIT: begin
        if (sts.key_match) begin
          cmd.res_load    = 1'b1;
          cmd.res_use_val = 1'b1;
          cmd.res_status  = ST_OK;
          state_next      = sts.is_delete ? S_DEL : S_OUT;
        end else begin
          cmd.walk_adv = 1'b1;
          state_next   = S_WALK;
        end
      end
      S_DEL: begin
        cmd.del_commit = 1'b1;
        state_next     = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

endmodule

// File: src/chained_hash_table_unit.sv
// ----------------------------------------------------------------------------
// chained_hash_table_unit: separate chaining hash table over a fixed node pool
// insert: modulo, head read, then node write, plus a chain link on a non-empty
//   bucket; lookup and delete: modulo, head read, then a chain walk node by
//   node; a full pool ends an insert right after the head read
// one item at a time; next item accepted once the result sits in the output
// reset: clearing pass over max(MAX_BUCKETS, POOL_DEPTH) entries, no item taken
// ----------------------------------------------------------------------------
module chained_hash_table_unit
  import cht_pkg::*;
#(
  parameter int MAX_BUCKETS = 1024,
  parameter int POOL_DEPTH  = 1024,
  parameter int KEY_BITS    = 32,
  parameter int VALUE_BITS  = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // func[1:0], key[33:2], value[65:34], zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // status[1:0], value_out[33:2],
                                 // item_count[44:34], used_buckets[55:45]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cmd_t        cmd;
  sts_t        sts;
  logic [10:0] bucket_count;

  // configuration register
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) bucket_count <= BUCKET_COUNT_RESET;
    else if (psel && penable && pwrite && paddr == ADDR_BUCKET_COUNT)
      bucket_count <= pwdata[10:0];
  end
  assign prdata = (paddr == ADDR_BUCKET_COUNT) ? {21'b0, bucket_count} : 32'b0;

  cht_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cht_datapath #(
    .MAX_BUCKETS (MAX_BUCKETS),
    .POOL_DEPTH  (POOL_DEPTH),
    .KEY_BITS    (KEY_BITS),
    .VALUE_BITS  (VALUE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .bucket_count (bucket_count),
    .s_tdata      (s_tdata),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata)
  );

endmodule

// File: src/cht_checker.sv
// ----------------------------------------------------------------------------
// cht_checker
// port-level checks of the hash table, bound to the top level
// ----------------------------------------------------------------------------
`include "chained_hash_table_unit_defines.svh"

module cht_checker
  import cht_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [55:0] m_tdata
);

  // a stalled result holds
  `CHT_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")
  // status is one of the defined codes
  `CHT_ASSERT(a_status_code, m_tvalid |-> m_tdata[1:0] != ST_SPARE, "bad status code")
  // miss and full carry a zero value
  `CHT_ASSERT(a_zero_value, m_tvalid && m_tdata[1:0] != ST_OK |-> m_tdata[33:2] == 32'd0, "value on failed operation")
  // clearing pass blocks input and no result comes out of reset
  `CHT_ASSERT_RST(a_reset_quiet, rst |=> !s_tready && !m_tvalid, "activity right after reset")

endmodule

bind chained_hash_table_unit cht_checker u_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
